FILE: sv/lpgcb_pkg.sv
// ----------------------------------------------------------------------------
// lpgcb_pkg
// shared constants and types of the line point generator with color blend
// ----------------------------------------------------------------------------
`default_nettype none
package lpgcb_pkg;

   localparam int COORD_BITS = 11;
   localparam int FRAC_BITS  = 16;

   // half-pixel position width, square root digit pairs and widths
   localparam int H_W      = COORD_BITS + 1;
   localparam int SQ_PAIRS = COORD_BITS + 2 + FRAC_BITS;
   localparam int ROOT_W   = SQ_PAIRS;
   localparam int V_W      = 2 * COORD_BITS + 4;
   localparam int ALU_W    = (SQ_PAIRS + 3 > 2 * COORD_BITS + 2) ?
                             SQ_PAIRS + 3 : 2 * COORD_BITS + 2;
   localparam int MA_W     = (FRAC_BITS + 1 > H_W) ? FRAC_BITS + 1 : H_W;
   localparam int MB_W     = H_W;
   localparam int P_W      = MA_W + MB_W;
   localparam int CNT_W    = $clog2(SQ_PAIRS + 1);
   localparam int SUM_W    = FRAC_BITS + 9;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_STEP = 1'b1;

   // result of the shared compare and subtract unit
   typedef struct packed {
      logic             ge;
      logic [ALU_W-1:0] diff;
   } sub_res_type;

   typedef enum logic [11:0] {
      ST_IDLE  = 12'b0000_0000_0001,
      ST_LMA   = 12'b0000_0000_0010,
      ST_LMB   = 12'b0000_0000_0100,
      ST_SQRT  = 12'b0000_0000_1000,
      ST_SMUL  = 12'b0000_0001_0000,
      ST_SDIV  = 12'b0000_0010_0000,
      ST_SMQ   = 12'b0000_0100_0000,
      ST_SMH   = 12'b0000_1000_0000,
      ST_RCMP  = 12'b0001_0000_0000,
      ST_RDIV  = 12'b0010_0000_0000,
      ST_BLEND = 12'b0100_0000_0000,
      ST_DONE  = 12'b1000_0000_0000
   } state_type;

endpackage
`default_nettype wire

FILE: sv/lpgcb_sub.sv
// ----------------------------------------------------------------------------
// lpgcb_sub
// shared compare and subtract unit for square root and division steps
// ----------------------------------------------------------------------------
`default_nettype none
module lpgcb_sub (
   input  wire logic [lpgcb_pkg::ALU_W-1:0] a,
   input  wire logic [lpgcb_pkg::ALU_W-1:0] b,
   output lpgcb_pkg::sub_res_type           res
);

   logic [lpgcb_pkg::ALU_W:0] wide;

   assign wide     = {1'b0, a} - {1'b0, b};
   assign res.ge   = ~wide[lpgcb_pkg::ALU_W];
   assign res.diff = wide[lpgcb_pkg::ALU_W-1:0];

endmodule
`default_nettype wire

FILE: sv/lpgcb_mul.sv
// ----------------------------------------------------------------------------
// lpgcb_mul
// shared unsigned multiplier for squares, slope product and color weights
// ----------------------------------------------------------------------------
`default_nettype none
module lpgcb_mul (
   input  wire logic [lpgcb_pkg::MA_W-1:0] a,
   input  wire logic [lpgcb_pkg::MB_W-1:0] b,
   output logic      [lpgcb_pkg::P_W-1:0]  p
);

   assign p = lpgcb_pkg::P_W'(a) * lpgcb_pkg::P_W'(b);

endmodule
`default_nettype wire

FILE: sv/line_point_generator_color_blend.sv
// ----------------------------------------------------------------------------
// line_point_generator_color_blend
// line point walk with endpoint color blending, one shared subtract unit
// ----------------------------------------------------------------------------
// load item: squares of both spans, then the square root of their sum as the line length,
//   before the next item is taken; step item: from accept to result, in order:
//   slope multiply and divide, offset squares, square root, ratio compare,
//   ratio divide (skipped when the ratio saturates), 6 blend mults, then store
// one item in flight; result register lets the next item enter while it waits,
//   a finished step stalls in its last stage while the result register is full
// synchronous active-high reset: idle, no line active, no result pending
`default_nettype none
module line_point_generator_color_blend (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_opcode,
   input  wire logic [10:0] req_start_x,
   input  wire logic [10:0] req_start_y,
   input  wire logic [7:0]  req_start_red,
   input  wire logic [7:0]  req_start_green,
   input  wire logic [7:0]  req_start_blue,
   input  wire logic [10:0] req_end_x,
   input  wire logic [10:0] req_end_y,
   input  wire logic [7:0]  req_end_red,
   input  wire logic [7:0]  req_end_green,
   input  wire logic [7:0]  req_end_blue,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [10:0]      rsp_pixel_x,
   output logic [10:0]      rsp_pixel_y,
   output logic [7:0]       rsp_pixel_red,
   output logic [7:0]       rsp_pixel_green,
   output logic [7:0]       rsp_pixel_blue,
   output logic             rsp_last_pixel
);

   localparam int CB = lpgcb_pkg::COORD_BITS;
   localparam int FB = lpgcb_pkg::FRAC_BITS;

   lpgcb_pkg::state_type state_ff, state_in;

   // line state
   logic                          active_ff, active_in;
   logic                          dir_ff, dir_in;
   logic                          ydown_ff, ydown_in;
   logic [lpgcb_pkg::H_W-1:0]     pos_ff, pos_in;
   logic [CB-1:0]                 x1_ff, x1_in, y1_ff, y1_in;
   logic [CB-1:0]                 adx_ff, adx_in, ady_ff, ady_in;
   logic [7:0]                    sc_ff [3];
   logic [7:0]                    ec_ff [3];
   logic                          col_we;
   logic [lpgcb_pkg::ROOT_W-1:0]  total_ff, total_in;

   // working registers
   logic                          isload_ff, isload_in;
   logic [lpgcb_pkg::ALU_W-1:0]   acc_ff, acc_in;
   logic [lpgcb_pkg::ROOT_W-1:0]  root_ff, root_in;
   logic [lpgcb_pkg::V_W-1:0]     v_ff, v_in;
   logic [lpgcb_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic [CB-1:0]                 q_ff, q_in;
   logic [FB:0]                   ratio_ff, ratio_in;
   logic [lpgcb_pkg::SUM_W-1:0]   sum_ff, sum_in;
   logic [7:0]                    chan_ff [3];
   logic                          chan_we;

   // result register
   logic                          rvalid_ff, rvalid_in;
   logic                          out_we;
   logic [CB-1:0]                 ox_ff, oy_ff;
   logic [7:0]                    or_ff, og_ff, ob_ff;
   logic                          olast_ff;

   // shared units
   logic [lpgcb_pkg::ALU_W-1:0]   sub_a, sub_b;
   lpgcb_pkg::sub_res_type        sub_res;
   logic [lpgcb_pkg::MA_W-1:0]    mul_a;
   logic [lpgcb_pkg::MB_W-1:0]    mul_b;
   logic [lpgcb_pkg::P_W-1:0]     mul_p;

   logic [lpgcb_pkg::ALU_W-1:0]   den_ext;
   logic [FB:0]                   coeff;
   logic [1:0]                    ch;
   logic [lpgcb_pkg::ROOT_W-1:0]  root_next;
   logic [CB:0]                   h_inc;
   logic                          last;
   logic [CB-1:0]                 px, py;
   logic                          accept;

   lpgcb_sub u_sub (.a(sub_a), .b(sub_b), .res(sub_res));
   lpgcb_mul u_mul (.a(mul_a), .b(mul_b), .p(mul_p));

   assign req_ready = (state_ff == lpgcb_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;

   assign den_ext   = lpgcb_pkg::ALU_W'({adx_ff, 1'b0});
   assign coeff     = (FB+1)'(1 << FB) - ratio_ff;
   assign ch        = cnt_ff[2:1];
   assign root_next = {root_ff[lpgcb_pkg::ROOT_W-2:0], sub_res.ge};
   assign h_inc     = pos_ff + lpgcb_pkg::H_W'(1);
   assign last      = h_inc >= {adx_ff, 1'b0};
   // pixel x: left walk rounds the half step up
   assign px        = dir_ff ? x1_ff - CB'(h_inc >> 1) : x1_ff + CB'(pos_ff >> 1);
   assign py        = ydown_ff ? y1_ff - q_ff : y1_ff + q_ff;

   // operand selection for the shared units
   always_comb begin
      sub_a = '0;
      sub_b = '0;
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         lpgcb_pkg::ST_SQRT: begin
            sub_a = {acc_ff[lpgcb_pkg::ALU_W-3:0], v_ff[lpgcb_pkg::V_W-1 -: 2]};
            sub_b = lpgcb_pkg::ALU_W'({root_ff, 2'b01});
         end
         lpgcb_pkg::ST_SDIV: begin
            sub_a = acc_ff;
            sub_b = den_ext << cnt_ff;
         end
         lpgcb_pkg::ST_RCMP: begin
            sub_a = lpgcb_pkg::ALU_W'(root_ff);
            sub_b = lpgcb_pkg::ALU_W'({total_ff, 1'b0});
         end
         lpgcb_pkg::ST_RDIV: begin
            sub_a = {acc_ff[lpgcb_pkg::ALU_W-2:0], 1'b0};
            sub_b = lpgcb_pkg::ALU_W'({total_ff, 1'b0});
         end
         lpgcb_pkg::ST_LMA: begin
            mul_a = lpgcb_pkg::MA_W'(adx_ff);
            mul_b = lpgcb_pkg::MB_W'(adx_ff);
         end
         lpgcb_pkg::ST_LMB: begin
            mul_a = lpgcb_pkg::MA_W'(ady_ff);
            mul_b = lpgcb_pkg::MB_W'(ady_ff);
         end
         lpgcb_pkg::ST_SMUL: begin
            mul_a = lpgcb_pkg::MA_W'(pos_ff);
            mul_b = lpgcb_pkg::MB_W'(ady_ff);
         end
         lpgcb_pkg::ST_SMQ: begin
            mul_a = lpgcb_pkg::MA_W'(q_ff);
            mul_b = lpgcb_pkg::MB_W'(q_ff);
         end
         lpgcb_pkg::ST_SMH: begin
            mul_a = lpgcb_pkg::MA_W'(pos_ff);
            mul_b = lpgcb_pkg::MB_W'(pos_ff);
         end
         lpgcb_pkg::ST_BLEND: begin
            mul_a = cnt_ff[0] ? lpgcb_pkg::MA_W'(ratio_ff) : lpgcb_pkg::MA_W'(coeff);
            mul_b = cnt_ff[0] ? lpgcb_pkg::MB_W'(ec_ff[ch]) : lpgcb_pkg::MB_W'(sc_ff[ch]);
         end
         default: begin
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      active_in = active_ff;
      dir_in    = dir_ff;
      ydown_in  = ydown_ff;
      pos_in    = pos_ff;
      x1_in     = x1_ff;
      y1_in     = y1_ff;
      adx_in    = adx_ff;
      ady_in    = ady_ff;
      total_in  = total_ff;
      isload_in = isload_ff;
      acc_in    = acc_ff;
      root_in   = root_ff;
      v_in      = v_ff;
      cnt_in    = cnt_ff;
      q_in      = q_ff;
      ratio_in  = ratio_ff;
      sum_in    = sum_ff;
      col_we    = 1'b0;
      chan_we   = 1'b0;
      out_we    = 1'b0;
      rvalid_in = rvalid_ff && !rsp_ready;
      case (state_ff)
         lpgcb_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_opcode == lpgcb_pkg::OP_LOAD) begin
                  col_we    = 1'b1;
                  x1_in     = req_start_x;
                  y1_in     = req_start_y;
                  dir_in    = req_start_x > req_end_x;
                  ydown_in  = req_end_y < req_start_y;
                  adx_in    = (req_start_x > req_end_x) ? req_start_x - req_end_x
                                                        : req_end_x - req_start_x;
                  ady_in    = (req_start_y > req_end_y) ? req_start_y - req_end_y
                                                        : req_end_y - req_start_y;
                  pos_in    = '0;
                  active_in = req_start_x != req_end_x;
                  isload_in = 1'b1;
                  // equal-x line: nothing more to compute
                  if (req_start_x != req_end_x) begin
                     state_in = lpgcb_pkg::ST_LMA;
                  end
               end else if (active_ff) begin
                  isload_in = 1'b0;
                  state_in  = lpgcb_pkg::ST_SMUL;
               end
            end
         end
         lpgcb_pkg::ST_LMA: begin
            acc_in   = lpgcb_pkg::ALU_W'(mul_p);
            state_in = lpgcb_pkg::ST_LMB;
         end
         lpgcb_pkg::ST_LMB: begin
            v_in     = lpgcb_pkg::V_W'(acc_ff) + lpgcb_pkg::V_W'(mul_p);
            acc_in   = '0;
            root_in  = '0;
            cnt_in   = lpgcb_pkg::CNT_W'(lpgcb_pkg::SQ_PAIRS - 1);
            state_in = lpgcb_pkg::ST_SQRT;
         end
         lpgcb_pkg::ST_SQRT: begin
            // one root digit per cycle, radicand pairs shift out of v
            acc_in  = sub_res.ge ? sub_res.diff : sub_a;
            root_in = root_next;
            v_in    = {v_ff[lpgcb_pkg::V_W-3:0], 2'b00};
            cnt_in  = cnt_ff - lpgcb_pkg::CNT_W'(1);
            if (cnt_ff == '0) begin
               if (isload_ff) begin
                  total_in = root_next;
                  state_in = lpgcb_pkg::ST_IDLE;
               end else begin
                  state_in = lpgcb_pkg::ST_RCMP;
               end
            end
         end
         lpgcb_pkg::ST_SMUL: begin
            // upward walk floors, downward walk rounds the offset up
            acc_in   = lpgcb_pkg::ALU_W'(mul_p) +
                       (ydown_ff ? den_ext - lpgcb_pkg::ALU_W'(1) : '0);
            root_in  = '0;
            cnt_in   = lpgcb_pkg::CNT_W'(CB - 1);
            state_in = lpgcb_pkg::ST_SDIV;
         end
         lpgcb_pkg::ST_SDIV: begin
            acc_in  = sub_res.ge ? sub_res.diff : acc_ff;
            root_in = root_next;
            cnt_in  = cnt_ff - lpgcb_pkg::CNT_W'(1);
            if (cnt_ff == '0) begin
               q_in     = root_next[CB-1:0];
               state_in = lpgcb_pkg::ST_SMQ;
            end
         end
         lpgcb_pkg::ST_SMQ: begin
            acc_in   = lpgcb_pkg::ALU_W'(mul_p) << 2;
            state_in = lpgcb_pkg::ST_SMH;
         end
         lpgcb_pkg::ST_SMH: begin
            v_in     = lpgcb_pkg::V_W'(acc_ff) + lpgcb_pkg::V_W'(mul_p);
            acc_in   = '0;
            root_in  = '0;
            cnt_in   = lpgcb_pkg::CNT_W'(lpgcb_pkg::SQ_PAIRS - 1);
            state_in = lpgcb_pkg::ST_SQRT;
         end
         lpgcb_pkg::ST_RCMP: begin
            // distance at or past the full length saturates the ratio
            if (total_ff == '0 || sub_res.ge) begin
               ratio_in = (FB+1)'(1 << FB);
               cnt_in   = '0;
               state_in = lpgcb_pkg::ST_BLEND;
            end else begin
               acc_in   = lpgcb_pkg::ALU_W'(root_ff);
               root_in  = '0;
               cnt_in   = lpgcb_pkg::CNT_W'(FB - 1);
               state_in = lpgcb_pkg::ST_RDIV;
            end
         end
         lpgcb_pkg::ST_RDIV: begin
            acc_in  = sub_res.ge ? sub_res.diff : sub_a;
            root_in = root_next;
            cnt_in  = cnt_ff - lpgcb_pkg::CNT_W'(1);
            if (cnt_ff == '0) begin
               ratio_in = (FB+1)'(root_next[FB-1:0]);
               cnt_in   = '0;
               state_in = lpgcb_pkg::ST_BLEND;
            end
         end
         lpgcb_pkg::ST_BLEND: begin
            // even count: start weight, odd count: end weight, then store
            sum_in = (cnt_ff[0] ? sum_ff : '0) + lpgcb_pkg::SUM_W'(mul_p);
            cnt_in = cnt_ff + lpgcb_pkg::CNT_W'(1);
            if (cnt_ff[0]) begin
               chan_we = 1'b1;
            end
            if (cnt_ff == lpgcb_pkg::CNT_W'(5)) begin
               state_in = lpgcb_pkg::ST_DONE;
            end
         end
         lpgcb_pkg::ST_DONE: begin
            // wait for the result register to free up
            if (!rvalid_ff || rsp_ready) begin
               out_we    = 1'b1;
               rvalid_in = 1'b1;
               if (last) begin
                  active_in = 1'b0;
               end else begin
                  pos_in = h_inc[lpgcb_pkg::H_W-1:0];
               end
               state_in = lpgcb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lpgcb_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= lpgcb_pkg::ST_IDLE;
         active_ff <= 1'b0;
         rvalid_ff <= 1'b0;
         dir_ff    <= 1'b0;
         pos_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         active_ff <= active_in;
         rvalid_ff <= rvalid_in;
         dir_ff    <= dir_in;
         pos_ff    <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      ydown_ff  <= ydown_in;
      x1_ff     <= x1_in;
      y1_ff     <= y1_in;
      adx_ff    <= adx_in;
      ady_ff    <= ady_in;
      total_ff  <= total_in;
      isload_ff <= isload_in;
      acc_ff    <= acc_in;
      root_ff   <= root_in;
      v_ff      <= v_in;
      cnt_ff    <= cnt_in;
      q_ff      <= q_in;
      ratio_ff  <= ratio_in;
      sum_ff    <= sum_in;
      if (col_we) begin
         sc_ff[0] <= req_start_red;
         sc_ff[1] <= req_start_green;
         sc_ff[2] <= req_start_blue;
         ec_ff[0] <= req_end_red;
         ec_ff[1] <= req_end_green;
         ec_ff[2] <= req_end_blue;
      end
      if (chan_we) begin
         chan_ff[ch] <= sum_in[FB+7:FB];
      end
      if (out_we) begin
         ox_ff    <= px;
         oy_ff    <= py;
         or_ff    <= chan_ff[0];
         og_ff    <= chan_ff[1];
         ob_ff    <= chan_ff[2];
         olast_ff <= last;
      end
   end

   assign rsp_valid       = rvalid_ff;
   assign rsp_pixel_x     = ox_ff;
   assign rsp_pixel_y     = oy_ff;
   assign rsp_pixel_red   = or_ff;
   assign rsp_pixel_green = og_ff;
   assign rsp_pixel_blue  = ob_ff;
   assign rsp_last_pixel  = olast_ff;

   // a step is only worked on for an active line
   a_step_active: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lpgcb_pkg::ST_SMUL) |-> active_ff)
      else $error("step started without an active line");

   // a result appears only out of the final stage
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rvalid_ff) |-> $past(state_ff == lpgcb_pkg::ST_DONE))
      else $error("result raised outside the final stage");

   // the ratio divide never runs on a zero length
   a_ratio_den: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lpgcb_pkg::ST_RDIV) |-> (total_ff != '0))
      else $error("ratio divide with zero length");

endmodule
`default_nettype wire
